// ===== rtl/core/pwm_frequency_and_signed_duty_setter_unit_defines.svh =====
// Assertion macros for the PWM set-point unit.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef PWM_FREQUENCY_AND_SIGNED_DUTY_SETTER_UNIT_DEFINES_SVH
`define PWM_FREQUENCY_AND_SIGNED_DUTY_SETTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define PWMFDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define PWMFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pwmfds_pkg.sv =====
// Shared types and constants of the PWM set-point unit.
// No dependencies; imported by the controller, the datapath and the top level.
package pwmfds_pkg;

    // Field and register widths
    localparam int FREQ_W  = 32;
    localparam int DUTY_W  = 16;
    localparam int CLK_W   = 29;
    localparam int PSC_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 29;
    localparam int MAG_W   = 10;
    localparam int CNT_W   = 6;

    // Compare pipeline widths: (period+1) = 1000*qa + ra
    localparam int QA_W          = 23;  // floor(2^32/1000) fits here
    localparam int RA_W          = 10;
    localparam int T_W           = 20;  // ra*900+500 fits here
    localparam int RCP_WIDE_W    = 31;
    localparam int RCP_WIDE_SH   = 37;
    localparam int RCP_NARROW_W  = 18;
    localparam int RCP_NARROW_SH = 24;
    localparam int QA_PROD_W     = FREQ_W - 2 + RCP_WIDE_W;
    localparam int FRAC_PROD_W   = T_W - 3 + RCP_NARROW_W;

    // Command codes
    localparam logic CMD_SET_FREQ = 1'b0;
    localparam logic CMD_SET_DUTY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_CNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EN_PIN_USED = 2'd3;

    // Arithmetic constants
    localparam logic signed [DUTY_W-1:0] DUTY_LIMIT     = 16'sd900;
    localparam logic signed [DUTY_W-1:0] DUTY_LIMIT_NEG = -16'sd900;
    localparam logic [MAG_W-1:0]         MAG_LIMIT      = 10'd900;
    localparam logic [T_W-1:0]           ROUND_HALF     = 20'd500;
    localparam logic [RA_W-1:0]          PER_MILLE      = 10'd1000;
    localparam logic [FREQ_W-1:0]        NARROW_MAX     = 32'h0000_ffff;

    // Reciprocals of 125 (x/1000 = (x>>3)/125), exact over the operand ranges used
    localparam logic [RCP_WIDE_W-1:0]    RCP_WIDE       = 31'd1099511628;  // ceil(2^37/125)
    localparam logic [RCP_NARROW_W-1:0]  RCP_NARROW     = 18'd134218;      // ceil(2^24/125)

    // Reset values
    localparam logic [CLK_W-1:0]  TIMER_CLOCK_RST = 29'd84000000;
    localparam logic [FREQ_W-1:0] PERIOD_RST      = 32'd65535;

    // Step counts: divider bits for frequency, pipeline stages for duty
    localparam logic [CNT_W-1:0] FREQ_STEPS = 6'(CLK_W);
    localparam logic [CNT_W-1:0] DUTY_STEPS = 6'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_load;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// ===== rtl/core/pwmfds_ctrl.sv =====
// Sequencer of the PWM set-point unit: input/output handshakes and datapath steps.
// Depends on pwmfds_pkg.
module pwmfds_ctrl
    import pwmfds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                dp_cmd.mul = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                dp_cmd.div_load = 1'b1;
                state_next      = ST_DIV;
            end
            ST_DIV:
            begin
                if (dp_status.div_done)
                    state_next = ST_FIN;
                else
                    dp_cmd.div_step = 1'b1;
            end
            ST_FIN:
            begin
                // wait until the previous result has been taken
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result slot: set on commit, cleared by an output transfer
    always_comb
    begin
        if (dp_cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/pwmfds_dp.sv =====
// Datapath of the PWM set-point unit: config registers, prescaler multiplier, restoring
// divider, reciprocal compare pipeline and the period/compare/direction/enable state.
// Depends on pwmfds_pkg.
module pwmfds_dp
    import pwmfds_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data,
    input  logic                     cmd,
    input  logic [FREQ_W-1:0]        frequency,
    input  logic signed [DUTY_W-1:0] duty,
    input  dp_cmd_t                  dp_cmd,
    output dp_status_t               dp_status,
    output logic [FREQ_W-1:0]        period,
    output logic [FREQ_W-1:0]        compare,
    output logic                     direction,
    output logic                     drive_enable
);

    // Configuration
    logic [CLK_W-1:0] timer_clock_reg;
    logic [PSC_W-1:0] prescaler_reg;
    logic             wide_cnt_reg;
    logic             en_pin_used_reg;

    // Captured item
    logic                     cmd_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic signed [DUTY_W-1:0] duty_reg;

    // Divider
    logic [FREQ_W-1:0] prod_reg;
    logic [CLK_W-1:0]  dvd_reg;
    logic [FREQ_W-1:0] dsr_reg;
    logic [FREQ_W-1:0] rem_reg;
    logic [FREQ_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Compare pipeline
    logic [QA_W-1:0]   qa_reg;
    logic [RA_W-1:0]   ra_reg;
    logic [FREQ_W-1:0] qm_reg;
    logic [T_W-1:0]    t_reg;
    logic [FREQ_W-1:0] cmp_reg;

    // Architectural state
    logic [FREQ_W-1:0] period_reg;
    logic [FREQ_W-1:0] compare_reg;
    logic              direction_reg;
    logic              enable_reg;

    logic [FREQ_W-1:0] period_next;
    logic [FREQ_W-1:0] compare_next;
    logic              direction_next;
    logic              enable_next;

    logic [MAG_W-1:0]         mag;
    logic signed [DUTY_W-1:0] duty_neg;
    logic [FREQ_W-1:0]        psc_plus;
    logic [FREQ_W-1:0]        mul_full;
    logic [FREQ_W:0]          rem_shift;
    logic [FREQ_W:0]          rem_diff;
    logic                     rem_ge;
    logic [FREQ_W-1:0]        freq_period;
    logic [FREQ_W:0]          amp;
    logic [QA_PROD_W-1:0]     qa_prod;
    logic [FRAC_PROD_W-1:0]   frac_prod;
    logic [MAG_W-1:0]         frac;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= TIMER_CLOCK_RST;
            prescaler_reg   <= '0;
            wide_cnt_reg    <= 1'b0;
            en_pin_used_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMER_CLOCK: timer_clock_reg <= cfg_data;
                REG_PRESCALER:   prescaler_reg   <= cfg_data[PSC_W-1:0];
                REG_WIDE_CNT:    wide_cnt_reg    <= cfg_data[0];
                REG_EN_PIN_USED: en_pin_used_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Duty clamp to +/-900 and magnitude
    assign duty_neg = -duty_reg;
    always_comb
    begin
        if (duty_reg > DUTY_LIMIT || duty_reg < DUTY_LIMIT_NEG)
            mag = MAG_LIMIT;
        else if (duty_reg < 0)
            mag = duty_neg[MAG_W-1:0];
        else
            mag = duty_reg[MAG_W-1:0];
    end

    // Divisor freq*(psc+1), kept to 32 bits
    assign psc_plus = {{(FREQ_W-PSC_W){1'b0}}, prescaler_reg} + 32'd1;
    assign mul_full = freq_reg * psc_plus;

    // Restoring divider step
    assign rem_shift = {rem_reg, dvd_reg[CLK_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign rem_ge    = (rem_shift >= {1'b0, dsr_reg});

    assign dp_status.div_done = (cnt_reg == '0);

    // Compare = qa*mag + (ra*mag+500)/1000 with (period+1) = 1000*qa + ra
    assign amp       = {1'b0, period_reg} + 33'd1;
    assign qa_prod   = {31'd0, amp[FREQ_W:3]} * {30'd0, RCP_WIDE};
    assign frac_prod = {18'd0, t_reg[T_W-1:3]} * {17'd0, RCP_NARROW};
    assign frac      = frac_prod[RCP_NARROW_SH+MAG_W-1:RCP_NARROW_SH];

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (dp_cmd.div_load)
        begin
            cnt_reg <= (cmd_reg == CMD_SET_DUTY) ? DUTY_STEPS : FREQ_STEPS;
        end
        else if (dp_cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // Item capture, multiply, divide and compare pipeline registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_in)
        begin
            cmd_reg  <= cmd;
            freq_reg <= frequency;
            duty_reg <= duty;
        end
        if (dp_cmd.mul)
            prod_reg <= mul_full;
        if (dp_cmd.div_load)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            dvd_reg  <= timer_clock_reg;
            dsr_reg  <= prod_reg;
        end
        else if (dp_cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
            dvd_reg  <= {dvd_reg[CLK_W-2:0], 1'b0};
            quot_reg <= {quot_reg[FREQ_W-2:0], rem_ge};
        end
        // each stage feeds the next on a divider step; all are valid once the step count runs out
        if (dp_cmd.div_step)
        begin
            qa_reg  <= qa_prod[RCP_WIDE_SH+QA_W-1:RCP_WIDE_SH];
            ra_reg  <= amp[RA_W-1:0] - qa_reg[RA_W-1:0] * PER_MILLE;
            qm_reg  <= {9'd0, qa_reg} * {22'd0, mag};
            t_reg   <= {10'd0, ra_reg} * {10'd0, mag} + ROUND_HALF;
            cmp_reg <= qm_reg + {22'd0, frac};
        end
    end

    // Period from the quotient: zero divisor gives all ones, then a 16-bit clamp unless wide
    always_comb
    begin
        if (dsr_reg == '0)
            freq_period = '1;
        else
            freq_period = quot_reg - 32'd1;
        if (!wide_cnt_reg && freq_period > NARROW_MAX)
            freq_period = NARROW_MAX;
    end

    // Next architectural state
    always_comb
    begin
        period_next    = period_reg;
        compare_next   = compare_reg;
        direction_next = direction_reg;
        enable_next    = enable_reg;
        if (cmd_reg == CMD_SET_DUTY)
        begin
            compare_next = cmp_reg;
            if (duty_reg == 0)
            begin
                enable_next = 1'b0;
            end
            else
            begin
                enable_next    = 1'b1;
                direction_next = (duty_reg > 0);
            end
        end
        else
        begin
            period_next = freq_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RST;
            compare_reg   <= '0;
            direction_reg <= 1'b0;
            enable_reg    <= 1'b0;
        end
        else if (dp_cmd.commit)
        begin
            period_reg    <= period_next;
            compare_reg   <= compare_next;
            direction_reg <= direction_next;
            enable_reg    <= enable_next;
        end
    end

    assign period       = period_reg;
    assign compare      = compare_reg;
    assign direction    = direction_reg;
    assign drive_enable = en_pin_used_reg ? enable_reg : 1'b1;

endmodule

// ===== rtl/core/pwm_frequency_and_signed_duty_setter_unit.sv =====
// PWM set-point unit, top level: sequencer plus datapath.
// Depends on pwmfds_pkg, pwmfds_ctrl, pwmfds_dp and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries cmd, frequency and duty. cmd 0 sets
//   the period from timer clock, prescaler and frequency; cmd 1 sets compare,
//   direction and enable from a signed per-mille duty clamped to +/-900.
//   Output channel (out_valid/out_ready) returns one transfer per command with
//   period, compare, direction and drive_enable as now in force.
//   Config channel (cfg_valid/cfg_ready, always ready) writes timer clock,
//   prescaler, wide counter and enable-pin-used; write it only while idle.
// Sequence: a set-frequency command runs a restoring divider at one quotient bit a
//   cycle, 29 steps, with multiply and load before it and done and commit after
//   it. A set-duty command divides by 1000 through a four-stage reciprocal pipeline.
// Issue: one command in work at a time; the next input is taken the cycle after
//   commit.
// Reset: period 65535, compare 0, direction 0, enable 0, config at its defaults.
// Stall: a waiting result holds in its output register; the next command is
//   taken and computed, then waits before commit until that result is taken.

`include "pwm_frequency_and_signed_duty_setter_unit_defines.svh"

module pwm_frequency_and_signed_duty_setter_unit
    import pwmfds_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic [FREQ_W-1:0]        frequency,
    input  logic signed [DUTY_W-1:0] duty,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FREQ_W-1:0]        period,
    output logic [FREQ_W-1:0]        compare,
    output logic                     direction,
    output logic                     drive_enable
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    pwmfds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    pwmfds_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .frequency    (frequency),
        .duty         (duty),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .period       (period),
        .compare      (compare),
        .direction    (direction),
        .drive_enable (drive_enable)
    );

    // Checks
    `PWMFDS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "took a second input while busy")
    `PWMFDS_ASSERT_SAME(a_result_from_commit, $rose(out_valid), $past(dp_cmd.commit), "result raised without commit")
    `PWMFDS_ASSERT_SAME(a_disabled_zero_cmp, !drive_enable, compare == '0, "driver off with nonzero compare")

endmodule
